// ===== sv/paeb_pkg.sv =====
// Shared types, codes and constants of the polyphonic ADSR envelope bank.
`default_nettype none

package paeb_pkg;

   // Default number of voices in the ring.
   localparam int VOICE_COUNT_DEF = 8;
   // Only the first voices of a tick are reported.
   localparam int MAX_RESULTS = 8;

   localparam int LEVEL_W = 32;
   localparam int NOTE_W = 7;
   localparam int VEL_W = 7;
   localparam int INDEX_W = 3;
   localparam int AMP_W = 16;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = 32'hFFFF_FFFF;

   // Division by 127 of a value below 2^23: multiply by ceil(2^30 / 127), shift by 30.
   localparam int AMP_Y_W = 23;
   localparam int AMP_RECIP_W = 24;
   localparam int AMP_RECIP_SHIFT = 30;
   localparam logic [AMP_RECIP_W-1:0] AMP_RECIP = 24'd8454661;

   // Transaction codes on the request channel.
   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_NOTE_ON  = 2'd1,
      REQ_NOTE_OFF = 2'd2,
      REQ_ALL_OFF  = 2'd3
   } req_op_type;

   // Envelope stage codes.
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_ATTACK  = 3'd1,
      ST_DECAY   = 3'd2,
      ST_SUSTAIN = 3'd3,
      ST_RELEASE = 3'd4
   } stage_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ATTACK_STEP   = 2'd0,
      CSR_DECAY_STEP    = 2'd1,
      CSR_SUSTAIN_LEVEL = 2'd2,
      CSR_RELEASE_RATE  = 2'd3
   } csr_index_type;

   localparam logic [LEVEL_W-1:0] ATTACK_STEP_RST = 32'd8947848;
   localparam logic [LEVEL_W-1:0] DECAY_STEP_RST = 32'd59652;
   localparam logic [LEVEL_W-1:0] SUSTAIN_LEVEL_RST = 32'd3435973836;
   localparam logic [LEVEL_W-1:0] RELEASE_RATE_RST = 32'd178957;

   typedef struct packed {
      logic [LEVEL_W-1:0] attack_step;
      logic [LEVEL_W-1:0] decay_step;
      logic [LEVEL_W-1:0] sustain_level;
      logic [LEVEL_W-1:0] release_rate;
   } cfg_type;

   // State of one voice, as held in a ring cell.
   typedef struct packed {
      logic               active;
      stage_type          stage;
      logic [LEVEL_W-1:0] level;
      logic [NOTE_W-1:0]  note;
      logic [VEL_W-1:0]   velocity;
      logic [LEVEL_W-1:0] release_step;
   } voice_type;

   localparam voice_type VOICE_RST = '{
      active:       1'b0,
      stage:        ST_IDLE,
      level:        '0,
      note:         '0,
      velocity:     '0,
      release_step: '0
   };

   // A stepped voice on its way to the amplitude pipeline.
   typedef struct packed {
      logic               active;
      stage_type          stage;
      logic [LEVEL_W-1:0] level;
      logic [VEL_W-1:0]   velocity;
      logic [INDEX_W-1:0] index;
      logic               last;
   } amp_in_type;

endpackage

`default_nettype wire

// ===== sv/paeb_cell.sv =====
// One cell of the voice ring: holds a voice and passes it on to its neighbour.
`default_nettype none

module paeb_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  shift_en,
   input  paeb_pkg::voice_type  voice_in,
   output paeb_pkg::voice_type  voice_out
);

   paeb_pkg::voice_type voice_ff;

   // The whole ring moves one place whenever a transaction is being worked on and no result is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_ff <= paeb_pkg::VOICE_RST;
      end else if (shift_en) begin
         voice_ff <= voice_in;
      end
   end

   assign voice_out = voice_ff;

endmodule

`default_nettype wire

// ===== sv/paeb_step.sv =====
// Shared voice update unit at the head of the ring: one voice per cycle while no result is held.
`default_nettype none

module paeb_step (
   input  paeb_pkg::voice_type     voice_in,
   input  paeb_pkg::req_op_type    op,
   input  wire [6:0]               note,
   input  wire [6:0]               velocity,
   input  wire                     alloc,
   input  paeb_pkg::cfg_type       cfg,
   output paeb_pkg::voice_type     voice_out
);

   logic [32:0] attack_sum;
   logic [63:0] release_prod;
   logic [31:0] release_hi;

   assign attack_sum = {1'b0, voice_in.level} + {1'b0, cfg.attack_step};
   assign release_prod = {32'd0, voice_in.level} * {32'd0, cfg.release_rate};
   assign release_hi = release_prod[63:32];

   // Apply the current transaction to the voice at the head of the ring.
   always_comb begin
      voice_out = voice_in;
      case (op)
         paeb_pkg::REQ_TICK: begin
            if (voice_in.active) begin
               case (voice_in.stage)
                  paeb_pkg::ST_ATTACK: begin
                     if (attack_sum >= {1'b0, paeb_pkg::FULL_SCALE}) begin
                        voice_out.level = paeb_pkg::FULL_SCALE;
                        voice_out.stage = paeb_pkg::ST_DECAY;
                     end else begin
                        voice_out.level = attack_sum[31:0];
                     end
                  end
                  paeb_pkg::ST_DECAY: begin
                     if (voice_in.level < cfg.decay_step ||
                         (voice_in.level - cfg.decay_step) <= cfg.sustain_level) begin
                        voice_out.level = cfg.sustain_level;
                        voice_out.stage = paeb_pkg::ST_SUSTAIN;
                     end else begin
                        voice_out.level = voice_in.level - cfg.decay_step;
                     end
                  end
                  paeb_pkg::ST_SUSTAIN: begin
                     voice_out.level = cfg.sustain_level;
                  end
                  paeb_pkg::ST_RELEASE: begin
                     if (voice_in.level <= voice_in.release_step) begin
                        voice_out.level = '0;
                        voice_out.stage = paeb_pkg::ST_IDLE;
                        voice_out.active = 1'b0;
                     end else begin
                        voice_out.level = voice_in.level - voice_in.release_step;
                     end
                  end
                  default: begin
                     voice_out.stage = paeb_pkg::ST_IDLE;
                     voice_out.active = 1'b0;
                  end
               endcase
            end
         end
         paeb_pkg::REQ_NOTE_ON: begin
            if (alloc) begin
               voice_out.note = note;
               voice_out.velocity = velocity;
               voice_out.level = '0;
               voice_out.stage = paeb_pkg::ST_ATTACK;
               voice_out.active = 1'b1;
            end
         end
         paeb_pkg::REQ_NOTE_OFF: begin
            // The release step is a share of the level at release, never below one.
            if (voice_in.active && voice_in.note == note &&
                voice_in.stage != paeb_pkg::ST_RELEASE) begin
               voice_out.release_step = (release_hi == '0) ? 32'd1 : release_hi;
               voice_out.stage = paeb_pkg::ST_RELEASE;
            end
         end
         paeb_pkg::REQ_ALL_OFF: begin
            voice_out.active = 1'b0;
            voice_out.stage = paeb_pkg::ST_IDLE;
         end
         default: begin
            voice_out = voice_in;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/paeb_amp.sv =====
// Amplitude pipeline: level times velocity, divided by 127, into the result register.
`default_nettype none

module paeb_amp (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    advance,
   input  wire                    in_valid,
   input  paeb_pkg::amp_in_type   in_data,
   output logic                   out_valid,
   output logic [2:0]             out_index,
   output logic [15:0]            out_amplitude,
   output logic [2:0]             out_stage,
   output logic                   out_last
);

   paeb_pkg::amp_in_type a_ff;
   logic                 a_vld_ff;
   logic [22:0]          b_y_ff;
   logic [2:0]           b_index_ff;
   paeb_pkg::stage_type  b_stage_ff;
   logic                 b_last_ff;
   logic                 b_vld_ff;
   logic                 out_vld_ff;
   logic [2:0]           out_index_ff;
   logic [15:0]          out_amp_ff;
   logic [2:0]           out_stage_ff;
   logic                 out_last_ff;

   paeb_pkg::amp_in_type a_in;
   logic [38:0]          prod;
   logic [46:0]          quot;

   // An inactive voice reports level zero in the idle stage.
   always_comb begin
      a_in = in_data;
      if (!in_data.active) begin
         a_in.level = '0;
         a_in.stage = paeb_pkg::ST_IDLE;
      end
   end

   assign prod = {7'd0, a_ff.level} * {32'd0, a_ff.velocity};
   assign quot = {24'd0, b_y_ff} * {23'd0, paeb_pkg::AMP_RECIP};

   // Valid bits of the three stages advance whenever no result is held at the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         out_vld_ff <= b_vld_ff;
      end
   end

   // Payload: product stage, then reciprocal multiply for the division by 127.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_y_ff <= prod[38:16];
         b_index_ff <= a_ff.index;
         b_stage_ff <= a_ff.stage;
         b_last_ff <= a_ff.last;
         out_amp_ff <= quot[45:30];
         out_index_ff <= b_index_ff;
         out_stage_ff <= b_stage_ff;
         out_last_ff <= b_last_ff;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_index = out_index_ff;
   assign out_amplitude = out_amp_ff;
   assign out_stage = out_stage_ff;
   assign out_last = out_last_ff;

endmodule

`default_nettype wire

// ===== sv/polyphonic_adsr_envelope_bank_core.sv =====
// Top level of the polyphonic ADSR envelope bank: control, voice ring and result path.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    req_type, req_note_number, req_note_velocity
//   rsp_      out        rsp_valid/rsp_ready    rsp_voice_index, rsp_amplitude, rsp_stage,
//                                               rsp_last_voice
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// A transaction is accepted while the block is idle and then takes one turn of the voice
// ring through the shared update unit, one voice per cycle while no result is held;
// the next transaction is taken on the cycle after the turn ends. A tick's results pass
// from the head through the input, product and result registers of the amplitude pipeline. Reset is
// synchronous and restores register defaults and idle voices at once. A result held with
// rsp_ready low freezes the ring and the pipeline together.
`default_nettype none

module polyphonic_adsr_envelope_bank_core #(
   parameter int VOICE_COUNT = paeb_pkg::VOICE_COUNT_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_type,
   input  wire  [6:0]  req_note_number,
   input  wire  [6:0]  req_note_velocity,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_voice_index,
   output logic [15:0] rsp_amplitude,
   output logic [2:0]  rsp_stage,
   output logic        rsp_last_voice,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int EMIT_COUNT = (VOICE_COUNT < paeb_pkg::MAX_RESULTS) ?
                               VOICE_COUNT : paeb_pkg::MAX_RESULTS;

   paeb_pkg::cfg_type    cfg_ff;
   logic                 busy_ff;
   logic [VIDX_W-1:0]    cnt_ff;
   logic [VIDX_W-1:0]    slot_ff;
   paeb_pkg::req_op_type op_ff;
   logic [6:0]           note_ff;
   logic [6:0]           vel_ff;

   logic                 accept;
   logic                 advance;
   logic                 shift_en;
   logic                 turn_done;
   logic                 emit_now;
   logic [VIDX_W-1:0]    slot_in;
   paeb_pkg::req_op_type op_in;
   paeb_pkg::voice_type  cell_q [VOICE_COUNT];
   paeb_pkg::voice_type  step_d;
   paeb_pkg::amp_in_type amp_in;

   assign req_ready = !busy_ff;
   assign accept = req_valid && !busy_ff;
   assign advance = !rsp_valid || rsp_ready;
   assign shift_en = busy_ff && advance;
   assign turn_done = (cnt_ff == VIDX_W'(VOICE_COUNT - 1));
   assign emit_now = ({1'b0, cnt_ff} < (VIDX_W + 1)'(EMIT_COUNT));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_step <= paeb_pkg::ATTACK_STEP_RST;
         cfg_ff.decay_step <= paeb_pkg::DECAY_STEP_RST;
         cfg_ff.sustain_level <= paeb_pkg::SUSTAIN_LEVEL_RST;
         cfg_ff.release_rate <= paeb_pkg::RELEASE_RATE_RST;
      end else if (csr_we) begin
         case (paeb_pkg::csr_index_type'(csr_index))
            paeb_pkg::CSR_ATTACK_STEP:   cfg_ff.attack_step <= csr_wdata;
            paeb_pkg::CSR_DECAY_STEP:    cfg_ff.decay_step <= csr_wdata;
            paeb_pkg::CSR_SUSTAIN_LEVEL: cfg_ff.sustain_level <= csr_wdata;
            paeb_pkg::CSR_RELEASE_RATE:  cfg_ff.release_rate <= csr_wdata;
            default:                     cfg_ff <= cfg_ff;
         endcase
      end
   end

   // While idle the ring is in voice order, so the free voice is found at once.
   always_comb begin
      slot_in = '0;
      for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
         if (!cell_q[i].active) begin
            slot_in = VIDX_W'(i);
         end
      end
   end

   // A note on with zero velocity is handled as a note off.
   always_comb begin
      op_in = paeb_pkg::req_op_type'(req_type);
      if (op_in == paeb_pkg::REQ_NOTE_ON && req_note_velocity == '0) begin
         op_in = paeb_pkg::REQ_NOTE_OFF;
      end
   end

   // Transaction control: one turn of the ring per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (shift_en) begin
         if (turn_done) begin
            busy_ff <= 1'b0;
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
         note_ff <= req_note_number;
         vel_ff <= req_note_velocity;
         slot_ff <= slot_in;
      end
   end

   // Update unit at the head of the ring.
   paeb_step u_step (
      .voice_in  (cell_q[0]),
      .op        (op_ff),
      .note      (note_ff),
      .velocity  (vel_ff),
      .alloc     (cnt_ff == slot_ff),
      .cfg       (cfg_ff),
      .voice_out (step_d)
   );

   // Ring of voice cells; the updated head voice re-enters at the tail.
   for (genvar k = 0; k < VOICE_COUNT; k++) begin : g_ring
      if (k == VOICE_COUNT - 1) begin : g_tail
         paeb_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .voice_in  (step_d),
            .voice_out (cell_q[k])
         );
      end else begin : g_body
         paeb_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .voice_in  (cell_q[k + 1]),
            .voice_out (cell_q[k])
         );
      end
   end

   // Stepped voices of a tick feed the amplitude pipeline.
   always_comb begin
      amp_in.active = step_d.active;
      amp_in.stage = step_d.stage;
      amp_in.level = step_d.level;
      amp_in.velocity = step_d.velocity;
      amp_in.index = 3'(cnt_ff);
      amp_in.last = (cnt_ff == VIDX_W'(EMIT_COUNT - 1));
   end

   paeb_amp u_amp (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (shift_en && op_ff == paeb_pkg::REQ_TICK && emit_now),
      .in_data       (amp_in),
      .out_valid     (rsp_valid),
      .out_index     (rsp_voice_index),
      .out_amplitude (rsp_amplitude),
      .out_stage     (rsp_stage),
      .out_last      (rsp_last_voice)
   );

`ifndef SYNTHESIS
   // The ring position is back at the start whenever no transaction is in work.
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0)
      else $error("voice ring position not at start while idle");

   // An accepted transaction starts a turn from the first voice.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && cnt_ff == '0)
      else $error("accepted transaction did not start a ring turn");

   // The final result of a tick belongs to the last reported voice.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_voice |-> rsp_voice_index == 3'(EMIT_COUNT - 1))
      else $error("last voice flag on the wrong voice");

   // An idle voice always reports zero amplitude.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stage == paeb_pkg::ST_IDLE |-> rsp_amplitude == '0)
      else $error("idle voice with non-zero amplitude");
`endif

endmodule

`default_nettype wire
